// ===== rtl/dzt_pkg.sv =====
package dzt_pkg;

  // Default number of fraction bits of the direction and level outputs.
  localparam int FRAC_BITS_DEF = 15;

  // Field widths.
  localparam int IN_W  = 16;
  localparam int OUT_W = 16;
  localparam int CFG_W = 15;
  localparam int IDX_W = 2;

  // Full-scale raw deflection and its square.
  localparam int unsigned FULL_RAW = 32767;
  localparam logic [29:0] FULL2    = 30'(FULL_RAW * FULL_RAW);

  // Square root: 64-bit radicand, 32-bit root, one root bit per stage.
  localparam int SQ_IN_W   = 64;
  localparam int SQ_OUT_W  = 32;
  localparam int SQ_STAGES = 32;

  // Divider: quotient bits kept before saturation, and denominator width.
  localparam int QW    = 17;
  localparam int DIV_DW = 32;

  // Register indexes.
  localparam logic [IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [IDX_W-1:0] CFG_RADIAL = 2'd1;
  localparam logic [IDX_W-1:0] CFG_AXIAL  = 2'd2;

  // Register reset values.
  localparam logic [CFG_W-1:0] RST_RADIAL = 15'd3924;
  localparam logic [CFG_W-1:0] RST_AXIAL  = 15'd6554;

  // Per-sample information that rides next to the square root.
  typedef struct packed {
    logic        nx;
    logic        ny;
    logic        zone;
    logic        zx;
    logic        zy;
    logic [15:0] ax;
    logic [15:0] ay;
    logic [29:0] lvn0;
  } side_t;

  // Per-sample information that rides next to the dividers.
  typedef struct packed {
    logic nx;
    logic ny;
    logic zone;
    logic zx;
    logic zy;
    logic lz;
  } tail_t;

endpackage

// ===== rtl/thumbstick_dead_zone.sv =====
// Radial dead zone for one thumbstick sample per transaction.
// Depth: set by the 32-stage square root and the 18-stage dividers.
// Throughput: one sample enters each cycle unless the skid register is occupied.
// Reset (synchronous, active low): pipeline empty, mode 0, radius 3924,
// axial threshold 6554.
module thumbstick_dead_zone import dzt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  // Input stream. in_tdata: stick_x [15:0], stick_y [31:16].
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [31:0]      in_tdata,
  // Result stream. out_tdata: dir_x [15:0], dir_y [31:16], level [47:32].
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [47:0]      out_tdata,
  // out_tuser: inside_zone [0].
  output logic [0:0]       out_tuser,
  // Configuration write port.
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  // Numerators carry FRAC_BITS extra bits over a 32-bit unscaled value.
  localparam int NW = FRAC_BITS + 32;
  localparam logic [OUT_W-1:0] ONE_SAT =
    (FRAC_BITS >= OUT_W) ? {OUT_W{1'b1}} : OUT_W'(1 << FRAC_BITS);
  localparam logic [31:0] CAP = 32'(FULL_RAW) << 16;
  localparam int TAIL_DEPTH = QW + 1;

  // ------------------------------------------------------------------
  // Configuration registers and their squares.
  // ------------------------------------------------------------------
  logic             mode_r;
  logic [CFG_W-1:0] rad_r;
  logic [CFG_W-1:0] axz_r;
  logic [29:0]      rr_r;
  logic [29:0]      a2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      rad_r  <= RST_RADIAL;
      axz_r  <= RST_AXIAL;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:   mode_r <= cfg_wdata[0];
        CFG_RADIAL: rad_r  <= cfg_wdata;
        CFG_AXIAL:  axz_r  <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  // The squares are registered in the cycle after the registers change, well before a sample
  // reaches the stage that reads them.
  always_ff @(posedge clk) begin
    rr_r <= 30'(rad_r) * 30'(rad_r);
    a2_r <= 30'(axz_r) * 30'(axz_r);
  end

  // ------------------------------------------------------------------
  // Flow control. The whole pipeline moves together; it only holds while
  // the skid register is occupied, so a result waiting at the output does
  // not stop new transactions.
  // ------------------------------------------------------------------
  logic skid_v_r;
  logic adv;

  assign adv       = !skid_v_r;
  assign in_tready = adv;

  // ------------------------------------------------------------------
  // Stage 1: absolute values, squares, and the mode 0 axial test.
  // ------------------------------------------------------------------
  logic [15:0] ax_nxt, ay_nxt;
  logic [30:0] athr;

  assign ax_nxt = in_tdata[15] ? 16'(~in_tdata[15:0] + 16'd1) : in_tdata[15:0];
  assign ay_nxt = in_tdata[31] ? 16'(~in_tdata[31:16] + 16'd1) : in_tdata[31:16];
  assign athr   = 31'(axz_r) * 31'(FULL_RAW);

  logic        v1_r, nx1_r, ny1_r, zx0_1_r, zy0_1_r;
  logic [15:0] ax1_r, ay1_r;
  logic [31:0] ax2_1_r, ay2_1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nx1_r   <= in_tdata[15];
      ny1_r   <= in_tdata[31];
      ax1_r   <= ax_nxt;
      ay1_r   <= ay_nxt;
      ax2_1_r <= 32'(ax_nxt) * 32'(ax_nxt);
      ay2_1_r <= 32'(ay_nxt) * 32'(ay_nxt);
      zx0_1_r <= {ax_nxt, 15'd0} < athr;
      zy0_1_r <= {ay_nxt, 15'd0} < athr;
    end
  end

  // ------------------------------------------------------------------
  // Stage 2: squared magnitude.
  // ------------------------------------------------------------------
  logic        v2_r, nx2_r, ny2_r, zx0_2_r, zy0_2_r;
  logic [15:0] ax2s_r, ay2s_r;
  logic [31:0] ax2_2_r, ay2_2_r, m2_2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nx2_r   <= nx1_r;
      ny2_r   <= ny1_r;
      zx0_2_r <= zx0_1_r;
      zy0_2_r <= zy0_1_r;
      ax2s_r  <= ax1_r;
      ay2s_r  <= ay1_r;
      ax2_2_r <= ax2_1_r;
      ay2_2_r <= ay2_1_r;
      m2_2_r  <= ax2_1_r + ay2_1_r;
    end
  end

  // ------------------------------------------------------------------
  // Stage 3: dead zone test, mode 0 level numerator, and the product that
  // the mode 1 axial test compares against.
  // ------------------------------------------------------------------
  logic [31:0] mc_nxt;
  assign mc_nxt = (m2_2_r > 32'(FULL2)) ? 32'(FULL2) : m2_2_r;

  logic        v3_r, nx3_r, ny3_r, zx0_3_r, zy0_3_r, inside3_r;
  logic [15:0] ax3_r, ay3_r;
  logic [31:0] ax2_3_r, ay2_3_r, m2_3_r;
  logic [29:0] lvn0_3_r;
  logic [61:0] am_3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nx3_r     <= nx2_r;
      ny3_r     <= ny2_r;
      zx0_3_r   <= zx0_2_r;
      zy0_3_r   <= zy0_2_r;
      ax3_r     <= ax2s_r;
      ay3_r     <= ay2s_r;
      ax2_3_r   <= ax2_2_r;
      ay2_3_r   <= ay2_2_r;
      m2_3_r    <= m2_2_r;
      inside3_r <= m2_2_r <= 32'(rr_r);
      lvn0_3_r  <= 30'(mc_nxt - 32'(rr_r));
      am_3_r    <= 62'(a2_r) * 62'(m2_2_r);
    end
  end

  // ------------------------------------------------------------------
  // Square root with the sample information delayed beside it.
  // ------------------------------------------------------------------
  side_t side_in, side_out;
  logic  v_s;
  logic [SQ_OUT_W-1:0] s_val;

  always_comb begin
    side_in.nx   = nx3_r;
    side_in.ny   = ny3_r;
    side_in.zone = inside3_r;
    side_in.zx   = mode_r ? ({ax2_3_r, 30'd0} < am_3_r) : zx0_3_r;
    side_in.zy   = mode_r ? ({ay2_3_r, 30'd0} < am_3_r) : zy0_3_r;
    side_in.ax   = ax3_r;
    side_in.ay   = ay3_r;
    side_in.lvn0 = lvn0_3_r;
  end

  dzt_sqrt u_sqrt (
    .clk   (clk),
    .en    (adv),
    .v_in  ({m2_3_r, 32'd0}),
    .s_out (s_val)
  );

  dzt_delay #(.W($bits(side_t)), .DEPTH(SQ_STAGES)) u_side_dly (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .v_in  (v3_r),
    .d_in  (side_in),
    .v_out (v_s),
    .d_out (side_out)
  );

  // ------------------------------------------------------------------
  // Prep stage 1: numerators and denominators before scaling.
  // Mode 0 divides the clipped squared magnitude and uses full scale as
  // the direction divisor; mode 1 uses the root for both.
  // ------------------------------------------------------------------
  logic [31:0] c_nxt, rq_nxt;
  logic [31:0] ln_nxt, ld_nxt, xn_nxt, yn_nxt, dd_nxt;

  always_comb begin
    c_nxt  = (s_val > CAP) ? CAP : s_val;
    rq_nxt = {1'b0, rad_r, 16'd0};
    if (mode_r) begin
      ln_nxt = (c_nxt > rq_nxt) ? c_nxt - rq_nxt : 32'd0;
      ld_nxt = {1'b0, 15'(15'h7FFF - rad_r), 16'd0};
      xn_nxt = {side_out.ax, 16'd0};
      yn_nxt = {side_out.ay, 16'd0};
      dd_nxt = s_val;
    end else begin
      ln_nxt = 32'(side_out.lvn0);
      ld_nxt = 32'(FULL2 - rr_r);
      xn_nxt = 32'(side_out.ax);
      yn_nxt = 32'(side_out.ay);
      dd_nxt = 32'(FULL_RAW);
    end
  end

  logic        vp1_r;
  logic [31:0] ln_p1_r, ld_p1_r, xn_p1_r, yn_p1_r, dd_p1_r;
  tail_t       tail_p1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vp1_r <= 1'b0;
    else if (adv) vp1_r <= v_s;
  end

  // A zero level divisor means full radius; the level is then full scale.
  always_ff @(posedge clk) begin
    if (adv) begin
      ln_p1_r        <= ln_nxt;
      ld_p1_r        <= ld_nxt;
      xn_p1_r        <= xn_nxt;
      yn_p1_r        <= yn_nxt;
      dd_p1_r        <= dd_nxt;
      tail_p1_r.nx   <= side_out.nx;
      tail_p1_r.ny   <= side_out.ny;
      tail_p1_r.zone <= side_out.zone;
      tail_p1_r.zx   <= side_out.zx;
      tail_p1_r.zy   <= side_out.zy;
      tail_p1_r.lz   <= ld_nxt == 32'd0;
    end
  end

  // ------------------------------------------------------------------
  // Prep stage 2: scale by 2^FRAC_BITS and add half the divisor, so the
  // truncating dividers round half away from zero.
  // ------------------------------------------------------------------
  logic          vp2_r;
  logic [NW-1:0] lnum_r, xnum_r, ynum_r;
  logic [31:0]   ld_p2_r, dd_p2_r;
  tail_t         tail_p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vp2_r <= 1'b0;
    else if (adv) vp2_r <= vp1_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lnum_r    <= (NW'(ln_p1_r) << FRAC_BITS) + NW'(ld_p1_r >> 1);
      xnum_r    <= (NW'(xn_p1_r) << FRAC_BITS) + NW'(dd_p1_r >> 1);
      ynum_r    <= (NW'(yn_p1_r) << FRAC_BITS) + NW'(dd_p1_r >> 1);
      ld_p2_r   <= ld_p1_r;
      dd_p2_r   <= dd_p1_r;
      tail_p2_r <= tail_p1_r;
    end
  end

  // ------------------------------------------------------------------
  // Three pipelined dividers: level, x direction, y direction.
  // ------------------------------------------------------------------
  logic [QW-1:0] lq, xq, yq;
  logic          lovf, xovf, yovf;
  logic          v_t;
  tail_t         tail_out;

  dzt_div #(.NW(NW), .DW(DIV_DW), .QN(QW)) u_div_lvl (
    .clk (clk), .en (adv), .n_in (lnum_r), .d_in (ld_p2_r), .q_out (lq), .ovf_out (lovf)
  );

  dzt_div #(.NW(NW), .DW(DIV_DW), .QN(QW)) u_div_x (
    .clk (clk), .en (adv), .n_in (xnum_r), .d_in (dd_p2_r), .q_out (xq), .ovf_out (xovf)
  );

  dzt_div #(.NW(NW), .DW(DIV_DW), .QN(QW)) u_div_y (
    .clk (clk), .en (adv), .n_in (ynum_r), .d_in (dd_p2_r), .q_out (yq), .ovf_out (yovf)
  );

  dzt_delay #(.W($bits(tail_t)), .DEPTH(TAIL_DEPTH)) u_tail_dly (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .v_in  (vp2_r),
    .d_in  (tail_p2_r),
    .v_out (v_t),
    .d_out (tail_out)
  );

  // ------------------------------------------------------------------
  // Final stage: saturation, axial zeroing, and the dead zone override.
  // ------------------------------------------------------------------
  function automatic logic [OUT_W-1:0] sat_dir(input logic neg, input logic ovf,
                                               input logic [QW-1:0] q);
    logic [OUT_W-1:0] v;
    if (neg) begin
      v = (ovf || q > QW'(32768)) ? 16'h8000 : OUT_W'(QW'(0) - q);
    end else begin
      v = (ovf || q > QW'(32767)) ? 16'h7FFF : q[OUT_W-1:0];
    end
    return v;
  endfunction

  logic [OUT_W-1:0] dx_nxt, dy_nxt, lv_nxt;

  always_comb begin
    dx_nxt = tail_out.zx ? '0 : sat_dir(tail_out.nx, xovf, xq);
    dy_nxt = tail_out.zy ? '0 : sat_dir(tail_out.ny, yovf, yq);
    if (tail_out.lz) lv_nxt = ONE_SAT;
    else if (lovf || (lq >> OUT_W) != '0) lv_nxt = {OUT_W{1'b1}};
    else lv_nxt = lq[OUT_W-1:0];
    if (tail_out.zone) begin
      dx_nxt = '0;
      dy_nxt = '0;
      lv_nxt = '0;
    end
  end

  logic        vf_r;
  logic [47:0] df_r;
  logic        uf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vf_r <= 1'b0;
    else if (adv) vf_r <= v_t;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      df_r <= {lv_nxt, dy_nxt, dx_nxt};
      uf_r <= tail_out.zone;
    end
  end

  // ------------------------------------------------------------------
  // Output register with a skid register behind it. A result that cannot
  // leave goes to the skid register, and only then does the pipeline hold.
  // ------------------------------------------------------------------
  logic        out_v_r;
  logic [47:0] out_d_r, skid_d_r;
  logic        out_u_r, skid_u_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_tready) begin
        out_d_r  <= skid_d_r;
        out_u_r  <= skid_u_r;
        skid_v_r <= 1'b0;
      end
    end else if (out_v_r && !out_tready) begin
      if (vf_r) begin
        skid_d_r <= df_r;
        skid_u_r <= uf_r;
        skid_v_r <= 1'b1;
      end
    end else begin
      out_v_r <= vf_r;
      out_d_r <= df_r;
      out_u_r <= uf_r;
    end
  end

  assign out_tvalid   = out_v_r;
  assign out_tdata    = out_d_r;
  assign out_tuser[0] = out_u_r;

endmodule

// ===== rtl/dzt_delay.sv =====
module dzt_delay import dzt_pkg::*; #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         v_in,
  input  logic [W-1:0] d_in,
  output logic         v_out,
  output logic [W-1:0] d_out
);

  logic         v_r [DEPTH];
  logic [W-1:0] d_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= v_in;
      for (int i = 1; i < DEPTH; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0] <= d_in;
      for (int i = 1; i < DEPTH; i++) d_r[i] <= d_r[i-1];
    end
  end

  assign v_out = v_r[DEPTH-1];
  assign d_out = d_r[DEPTH-1];

endmodule

// ===== rtl/dzt_sqrt.sv =====
module dzt_sqrt import dzt_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic [SQ_IN_W-1:0]  v_in,
  output logic [SQ_OUT_W-1:0] s_out
);

  logic [SQ_IN_W-1:0] rem_r [SQ_STAGES];
  logic [SQ_IN_W-1:0] res_r [SQ_STAGES];

  // Digit-by-digit root, one result bit per stage.
  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
    localparam logic [SQ_IN_W-1:0] BITK = SQ_IN_W'(1) << (SQ_IN_W - 2 - 2 * k);
    logic [SQ_IN_W-1:0] rem_p;
    logic [SQ_IN_W-1:0] res_p;
    logic [SQ_IN_W-1:0] trial;

    if (k == 0) begin : g_first
      assign rem_p = v_in;
      assign res_p = '0;
    end else begin : g_next
      assign rem_p = rem_r[k-1];
      assign res_p = res_r[k-1];
    end

    assign trial = res_p + BITK;

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_p >= trial) begin
          rem_r[k] <= rem_p - trial;
          res_r[k] <= (res_p >> 1) + BITK;
        end else begin
          rem_r[k] <= rem_p;
          res_r[k] <= res_p >> 1;
        end
      end
    end
  end

  assign s_out = res_r[SQ_STAGES-1][SQ_OUT_W-1:0];

endmodule

// ===== rtl/dzt_div.sv =====
module dzt_div import dzt_pkg::*; #(
  parameter int NW = 47,
  parameter int DW = 32,
  parameter int QN = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] n_in,
  input  logic [DW-1:0] d_in,
  output logic [QN-1:0] q_out,
  output logic          ovf_out
);

  localparam int CW = (NW > DW + QN) ? NW : DW + QN;

  logic [CW-1:0] rem_r [QN+1];
  logic [DW-1:0] d_r   [QN];
  logic [QN-1:0] q_r   [QN+1];
  logic          ovf_r [QN+1];

  // The first stage flags a quotient that does not fit in QN bits.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= CW'(n_in);
      d_r[0]   <= d_in;
      q_r[0]   <= '0;
      ovf_r[0] <= CW'(n_in) >= (CW'(d_in) << QN);
    end
  end

  // Restoring division, one quotient bit per stage, highest bit first.
  for (genvar j = 1; j <= QN; j++) begin : g_stage
    localparam int SH = QN - j;
    logic [CW-1:0] sub;
    assign sub = CW'(d_r[j-1]) << SH;

    if (j < QN) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) d_r[j] <= d_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ovf_r[j] <= ovf_r[j-1];
        if (rem_r[j-1] >= sub) begin
          rem_r[j] <= rem_r[j-1] - sub;
          q_r[j]   <= q_r[j-1] | (QN'(1) << SH);
        end else begin
          rem_r[j] <= rem_r[j-1];
          q_r[j]   <= q_r[j-1];
        end
      end
    end
  end

  assign q_out   = q_r[QN];
  assign ovf_out = ovf_r[QN];

endmodule

// ===== dv/tb.sv =====
module tb;
  import dzt_pkg::*;

  // The block conditions one stick sample per transaction. The testbench
  // predicts each result from the sample and the current register settings
  // and compares it, field by field, with what comes out of the pipeline.

  typedef struct {
    logic [15:0] dir_x;
    logic [15:0] dir_y;
    logic [15:0] level;
    logic        zone;
  } stick_result_t;

  // Scoreboard: holds the predicted results in arrival order and counts
  // the mismatches.
  class stick_scoreboard;
    stick_result_t pending[$];
    int errors;
    int checked;

    function void note_sample(stick_result_t r);
      pending.push_back(r);
    endfunction

    function void check_result(logic [47:0] data, logic zone);
      stick_result_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h inside=%0d", data, zone);
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (data[15:0] !== exp_r.dir_x || data[31:16] !== exp_r.dir_y ||
          data[47:32] !== exp_r.level || zone !== exp_r.zone) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp dx=%h dy=%h lv=%h in=%0d got dx=%h dy=%h lv=%h in=%0d",
                   exp_r.dir_x, exp_r.dir_y, exp_r.level, exp_r.zone,
                   data[15:0], data[31:16], data[47:32], zone);
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [31:0]      in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [47:0]      out_tdata;
  logic [0:0]       out_tuser;
  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  thumbstick_dead_zone u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  stick_scoreboard sb = new();

  // Local copy of the register file, updated whenever the testbench writes.
  logic        cur_mode = 1'b0;
  logic [14:0] cur_radius = RST_RADIAL;
  logic [14:0] cur_axial = RST_AXIAL;

  // Idle control. While calm is set neither side idles; hold_off forces the
  // receiver to stall so the pipeline fills and back-pressures the input.
  bit calm = 0;
  bit hold_off = 0;
  int samples_sent = 0;

  function automatic longint unsigned round_div(longint unsigned n, longint unsigned d);
    return (n + d / 2) / d;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] clamp_dir(bit neg, longint unsigned mag);
    if (neg) return (mag > 32768) ? 16'h8000 : 16'(-longint'(mag));
    return (mag > 32767) ? 16'h7fff : 16'(mag);
  endfunction

  // Expected conditioning of one sample under the current settings.
  function automatic stick_result_t condition_stick(logic signed [15:0] sx,
                                                    logic signed [15:0] sy);
    stick_result_t r;
    longint unsigned one = 64'd1 << 15;
    longint unsigned ax = (sx < 0) ? -longint'(sx) : longint'(sx);
    longint unsigned ay = (sy < 0) ? -longint'(sy) : longint'(sy);
    longint unsigned m2 = ax * ax + ay * ay;
    longint unsigned rad = cur_radius;
    longint unsigned thr = cur_axial;
    longint unsigned full2 = 64'd32767 * 32767;
    longint unsigned lv, dx, dy, mc, den, s, cap, c, num;
    bit zx, zy;
    r = '{16'd0, 16'd0, 16'd0, 1'b1};
    if (m2 <= rad * rad) return r;
    if (!cur_mode) begin
      mc = (m2 > full2) ? full2 : m2;
      den = full2 - rad * rad;
      lv = (den == 0) ? one : round_div((mc - rad * rad) * one, den);
      dx = round_div(ax * one, 32767);
      dy = round_div(ay * one, 32767);
      zx = ax * 32768 < thr * 32767;
      zy = ay * 32768 < thr * 32767;
    end else begin
      s = int_sqrt(m2 << 32);
      cap = 64'd32767 << 16;
      c = (s > cap) ? cap : s;
      den = (64'd32767 - rad) << 16;
      num = (c > (rad << 16)) ? c - (rad << 16) : 0;
      lv = (den == 0) ? one : round_div(num * one, den);
      dx = round_div((ax * one) << 16, s);
      dy = round_div((ay * one) << 16, s);
      zx = ((ax * ax) << 30) < thr * thr * m2;
      zy = ((ay * ay) << 30) < thr * thr * m2;
    end
    r.dir_x = zx ? 16'd0 : clamp_dir(sx < 0, dx);
    r.dir_y = zy ? 16'd0 : clamp_dir(sy < 0, dy);
    r.level = (lv > 65535) ? 16'hffff : 16'(lv);
    r.zone = 1'b0;
    return r;
  endfunction

  // One register write, made only while the pipeline is empty. The caller
  // drops the write enable after the last write.
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_MODE:   cur_mode = val[0];
      CFG_RADIAL: cur_radius = val;
      CFG_AXIAL:  cur_axial = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(logic m, logic [14:0] rad, logic [14:0] thr);
    write_reg(CFG_MODE, {14'd0, m});
    write_reg(CFG_RADIAL, rad);
    write_reg(CFG_AXIAL, thr);
    cfg_we <= 1'b0;
  endtask

  // Offer one sample and hold it until the transaction completes.
  task automatic send_stick(logic [15:0] sx, logic [15:0] sy);
    while (!calm && $urandom_range(99) < 8) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {sy, sx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_sample(condition_stick(sx, sy));
    samples_sent++;
  endtask

  // Wait until every expected result has come, plus the pipeline depth.
  task automatic drain;
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_axis();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($urandom_range(8000)) - 16'd4000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_phase(int count);
    repeat (count) send_stick(pick_axis(), pick_axis());
  endtask

  // Receiver: random stalls, except during calm stretches or a forced hold-off.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser[0]);
    out_tready <= hold_off ? 1'b0 : (calm ? 1'b1 : ($urandom_range(99) >= 8));
  end

  // Long hold-off in its own process, counted in cycles.
  initial begin
    wait (samples_sent == 300);
    hold_off = 1;
    repeat (200) @(posedge clk);
    hold_off = 0;
  end

  initial begin
    #30000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed samples under the reset settings: center, the extremes of both axes (the most
    // negative sample saturates its direction), the radius edge, and diagonals.
    send_stick(16'h0000, 16'h0000);
    send_stick(16'h7fff, 16'h0000);
    send_stick(16'h8000, 16'h0000);
    send_stick(16'h0000, 16'h8000);
    send_stick(16'h0000, 16'h7fff);
    send_stick(16'h8000, 16'h8000);
    send_stick(16'h7fff, 16'h7fff);
    send_stick(16'd3924, 16'h0000);
    send_stick(16'd3925, 16'h0000);
    send_stick(16'h1000, 16'hf000);
    send_stick(16'hffff, 16'hffff);
    drain();
    // True-magnitude scheme with the same extremes.
    set_regs(1'b1, RST_RADIAL, RST_AXIAL);
    send_stick(16'h8000, 16'h0000);
    send_stick(16'h7fff, 16'h7fff);
    send_stick(16'h8000, 16'h8000);
    send_stick(16'h0100, 16'h7000);
    send_stick(16'd3925, 16'h0000);
    send_stick(16'h0001, 16'h0000);
    drain();
    // Zero radius and zero threshold; then full radius with a zero divisor.
    set_regs(1'b1, 15'd0, 15'd0);
    send_stick(16'h0001, 16'h0000);
    send_stick(16'hffff, 16'h0001);
    drain();
    set_regs(1'b0, 15'd32767, 15'd32767);
    send_stick(16'h8000, 16'h8000);
    send_stick(16'h7fff, 16'h0000);
    drain();
    set_regs(1'b1, 15'd32767, 15'd32767);
    send_stick(16'h8000, 16'h8000);
    send_stick(16'h7fff, 16'h0001);
    drain();

    // Random phases across several settings. The first phase includes the
    // long hold-off and then a calm stretch with no idling on either side.
    set_regs(1'b0, RST_RADIAL, RST_AXIAL);
    random_phase(400);
    calm = 1;
    random_phase(200);
    calm = 0;
    drain();
    set_regs(1'b1, RST_RADIAL, RST_AXIAL);
    random_phase(400);
    drain();
    set_regs(1'b0, 15'($urandom), 15'($urandom));
    random_phase(250);
    drain();
    set_regs(1'b1, 15'($urandom_range(20000)), 15'($urandom));
    random_phase(250);
    drain();
    set_regs(1'b1, 15'd0, 15'd32767);
    random_phase(125);
    drain();
    set_regs(1'b0, 15'd32766, 15'd0);
    random_phase(125);
    drain();

    $display("Covered %0d samples in both magnitude schemes, radius and threshold extremes,",
             samples_sent);
    $display("and a long output stall; %0d results checked.", sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
